@@ src/crdu_pkg.sv @@
package crdu_pkg;

    // frame geometry
    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 240;
    localparam int CROP_EDGE  = 240;
    localparam int OUT_EDGE   = 64;

    // fixed field widths
    localparam int PIXEL_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int OUT_COORD_W = 6;
    localparam int XOFF_W      = 7;
    localparam int YOFF_W      = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 2;

    // rgb565 layout
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;
    localparam int RED_W     = 5;
    localparam int GREEN_W   = 6;
    localparam int BLUE_W    = 5;

    // counter widths
    localparam int SCOL_W = (SRC_WIDTH > 2) ? $clog2(SRC_WIDTH) : 1;
    localparam int SROW_W = $clog2(SRC_HEIGHT + 1);
    localparam int IDX_W  = $clog2(OUT_EDGE + 1);
    localparam int POS_W  = $clog2(CROP_EDGE + 1);
    localparam int REM_W  = (OUT_EDGE > 1) ? $clog2(OUT_EDGE) : 1;
    localparam int CMP_W  = $clog2(SRC_WIDTH + SRC_HEIGHT + CROP_EDGE + 256) + 1;

    // sample step: crop position advances by CROP_EDGE/OUT_EDGE per output index
    localparam int STEP_Q = CROP_EDGE / OUT_EDGE;
    localparam int STEP_R = CROP_EDGE % OUT_EDGE;

    // offset limits keep the window inside the frame
    localparam int X_LIM = (SRC_WIDTH > CROP_EDGE) ? SRC_WIDTH - CROP_EDGE : 0;
    localparam int Y_LIM = (SRC_HEIGHT > CROP_EDGE) ? SRC_HEIGHT - CROP_EDGE : 0;
    localparam int XOFF_DEFAULT = 40;
    localparam logic [XOFF_W-1:0] XOFF_RESET =
        (XOFF_DEFAULT > X_LIM) ? XOFF_W'(X_LIM) : XOFF_W'(XOFF_DEFAULT);
    localparam logic [YOFF_W-1:0] YOFF_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROP_X = 2'd0,
        CFG_CROP_Y = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [XOFF_W-1:0] xoff;
        logic [YOFF_W-1:0] yoff;
    } offsets_t;

    // output index with its crop sample position kept as quotient and remainder
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] pos;
        logic [REM_W-1:0] rem;
    } samp_t;

    typedef struct packed {
        logic                   emit;
        logic [OUT_COORD_W-1:0] col;
        logic [OUT_COORD_W-1:0] row;
        logic                   done;
    } decision_t;

    function automatic samp_t samp_advance(samp_t s);
        logic [REM_W:0] rsum;
        samp_t          n;
        rsum  = {1'b0, s.rem} + (REM_W+1)'(STEP_R);
        n.idx = s.idx + IDX_W'(1);
        if (rsum >= (REM_W+1)'(OUT_EDGE))
        begin
            n.rem = REM_W'(rsum - (REM_W+1)'(OUT_EDGE));
            n.pos = s.pos + POS_W'(STEP_Q) + POS_W'(1);
        end
        else
        begin
            n.rem = REM_W'(rsum);
            n.pos = s.pos + POS_W'(STEP_Q);
        end
        return n;
    endfunction

endpackage

@@ src/crdu_cfg_regs.sv @@
module crdu_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [crdu_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [crdu_pkg::CFG_DATA_W-1:0] wr_data,
    output crdu_pkg::offsets_t              offsets
);
    import crdu_pkg::*;

    logic [XOFF_W-1:0] xoff_reg, xoff_next;
    logic [YOFF_W-1:0] yoff_reg, yoff_next;
    logic [XOFF_W-1:0] x_wr;
    logic [YOFF_W-1:0] y_wr;

    // offsets are clamped on write so the window stays inside the frame
    always_comb
    begin
        x_wr = XOFF_W'(wr_data);
        y_wr = YOFF_W'(wr_data);
        if (CMP_W'(x_wr) > CMP_W'(X_LIM))
            x_wr = XOFF_W'(X_LIM);
        if (CMP_W'(y_wr) > CMP_W'(Y_LIM))
            y_wr = YOFF_W'(Y_LIM);
    end

    always_comb
    begin
        xoff_next = xoff_reg;
        yoff_next = yoff_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_CROP_X: xoff_next = x_wr;
                CFG_CROP_Y: yoff_next = y_wr;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xoff_reg <= XOFF_RESET;
            yoff_reg <= YOFF_RESET;
        end
        else
        begin
            xoff_reg <= xoff_next;
            yoff_reg <= yoff_next;
        end
    end

    assign offsets.xoff = xoff_reg;
    assign offsets.yoff = yoff_reg;

endmodule

@@ src/crdu_sampler.sv @@
module crdu_sampler (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  start,
    input  crdu_pkg::offsets_t    offsets,
    output crdu_pkg::decision_t   dec
);
    import crdu_pkg::*;

    logic [SCOL_W-1:0] src_col_reg, src_col_next, src_col_e;
    logic [SROW_W-1:0] src_row_reg, src_row_next, src_row_e;
    samp_t             col_reg, col_next, col_e;
    samp_t             row_reg, row_next, row_e;
    logic              row_hit;
    logic              emit;

    // frame start clears the counters before this pixel is used
    assign src_col_e = start ? '0 : src_col_reg;
    assign src_row_e = start ? '0 : src_row_reg;
    assign col_e     = start ? '0 : col_reg;
    assign row_e     = start ? '0 : row_reg;

    assign row_hit = (src_row_e < SROW_W'(SRC_HEIGHT))
                  && (row_e.idx < IDX_W'(OUT_EDGE))
                  && (CMP_W'(src_row_e) >= CMP_W'(offsets.yoff) + CMP_W'(row_e.pos));

    assign emit = row_hit
               && (col_e.idx < IDX_W'(OUT_EDGE))
               && (CMP_W'(src_col_e) >= CMP_W'(offsets.xoff) + CMP_W'(col_e.pos));

    always_comb
    begin
        src_col_next = src_col_e + SCOL_W'(1);
        src_row_next = src_row_e;
        row_next     = row_e;
        col_next     = emit ? samp_advance(col_e) : col_e;
        if (src_col_e == SCOL_W'(SRC_WIDTH - 1))
        begin
            src_col_next = '0;
            if (row_hit)
            begin
                row_next = samp_advance(row_e);
                col_next = '0;
            end
            if (src_row_e < SROW_W'(SRC_HEIGHT))
                src_row_next = src_row_e + SROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (fire)
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    assign dec.emit = emit;
    assign dec.col  = OUT_COORD_W'(col_e.idx);
    assign dec.row  = OUT_COORD_W'(row_e.idx);
    assign dec.done = (col_e.idx == IDX_W'(OUT_EDGE - 1))
                   && (row_e.idx == IDX_W'(OUT_EDGE - 1));

endmodule

@@ src/crdu_out_stage.sv @@
module crdu_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [crdu_pkg::PIXEL_W-1:0]     pixel,
    input  crdu_pkg::decision_t              dec,
    output logic                             slot_free,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [crdu_pkg::CHAN_W-1:0]      red,
    output logic [crdu_pkg::CHAN_W-1:0]      green,
    output logic [crdu_pkg::CHAN_W-1:0]      blue,
    output logic [crdu_pkg::OUT_COORD_W-1:0] out_col,
    output logic [crdu_pkg::OUT_COORD_W-1:0] out_row,
    output logic                             frame_done
);
    import crdu_pkg::*;

    logic                   valid_reg, valid_next;
    logic [CHAN_W-1:0]      red_reg, green_reg, blue_reg;
    logic [OUT_COORD_W-1:0] col_reg, row_reg;
    logic                   done_reg;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // widen 5/6/5 to 8 bits by a left shift
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= {pixel[RED_LSB +: RED_W], (CHAN_W-RED_W)'(0)};
            green_reg <= {pixel[GREEN_LSB +: GREEN_W], (CHAN_W-GREEN_W)'(0)};
            blue_reg  <= {pixel[0 +: BLUE_W], (CHAN_W-BLUE_W)'(0)};
            col_reg   <= dec.col;
            row_reg   <= dec.row;
            done_reg  <= dec.done;
        end
    end

    assign out_valid  = valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign out_col    = col_reg;
    assign out_row    = row_reg;
    assign frame_done = done_reg;

endmodule

@@ src/crop_downscale_rgb565_unpack_top.sv @@
// Center crop and nearest-neighbor downscale of an RGB565 camera stream. Pixels come in raster
// order over a 320x240 frame, one per item, with frame_start on the first pixel. A 240x240 window
// starting at column crop_x_offset (register 0, reset 40, clamped to 80) and row crop_y_offset
// (register 1, clamped to 0) is reduced to 64x64: output index i takes crop index floor(i*240/64).
// Each picked pixel comes out as 8-bit red, green and blue (5/6/5 bits shifted left) with its
// output column, row and frame_done on the last pixel. Pixels outside the picked grid give no
// item. The block takes one pixel per clock, except while a sampled pixel waits for the result
// register to free up: an input register feeds combinational counter and compare logic that
// writes the result register that drives out_valid. Configuration writes are always taken
// (cfg_ready is tied high) and must only happen while no pixel is in flight.
module crop_downscale_rgb565_unpack_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [crdu_pkg::PIXEL_W-1:0]     pixel,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [crdu_pkg::CHAN_W-1:0]      red,
    output logic [crdu_pkg::CHAN_W-1:0]      green,
    output logic [crdu_pkg::CHAN_W-1:0]      blue,
    output logic [crdu_pkg::OUT_COORD_W-1:0] out_col,
    output logic [crdu_pkg::OUT_COORD_W-1:0] out_row,
    output logic                             frame_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crdu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crdu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import crdu_pkg::*;

    // input register
    logic               s1_valid_reg, s1_valid_next;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               s1_start_reg;

    offsets_t           offsets;
    decision_t          dec;
    logic               slot_free;
    logic               s1_fire;
    logic               in_fire;

    assign cfg_ready = 1'b1;

    crdu_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .offsets  (offsets)
    );

    // a pixel that gives no item retires even while the result register is held
    assign s1_fire  = s1_valid_reg && (!dec.emit || slot_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= pixel;
            s1_start_reg <= frame_start;
        end
    end

    // source and output counters, decides whether this pixel is sampled
    crdu_sampler u_sampler (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .start   (s1_start_reg),
        .offsets (offsets),
        .dec     (dec)
    );

    // color widening and result register
    crdu_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_fire && dec.emit),
        .pixel      (s1_pixel_reg),
        .dec        (dec),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_done (frame_done)
    );

    // a sampled pixel never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && dec.emit) |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // a new item only enters when the held one retires
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!s1_valid_reg || s1_fire))
        else $error("input item dropped");

    // frame_done marks exactly the last grid position
    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |->
            (out_col == OUT_COORD_W'(OUT_EDGE - 1) && out_row == OUT_COORD_W'(OUT_EDGE - 1)))
        else $error("frame_done away from last pixel");

endmodule

@@ sim/crop_downscale_rgb565_unpack_top_test.sv @@
`timescale 1ns / 100ps

module crop_downscale_rgb565_unpack_top_test;

    import crdu_pkg::*;

    // frame geometry, kept apart from the package so a wrong constant there shows up
    localparam int FRAME_W   = 320;
    localparam int FRAME_H   = 240;
    localparam int WINDOW    = 240;
    localparam int GRID      = 64;
    localparam int WIN_X_MAX = (FRAME_W > WINDOW) ? FRAME_W - WINDOW : 0;
    localparam int WIN_Y_MAX = (FRAME_H > WINDOW) ? FRAME_H - WINDOW : 0;

    // register values after reset
    localparam int CROP_X_AT_RESET = 40;
    localparam int CROP_Y_AT_RESET = 0;

    // cycles with no item moving on any channel before the run is called hung
    localparam int QUIET_LIMIT = 1000;
    // cycles from accept to out_valid, with some margin
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [PIXEL_W-1:0] pix;
        logic               start;
    } cam_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]      red;
        logic [CHAN_W-1:0]      green;
        logic [CHAN_W-1:0]      blue;
        logic [OUT_COORD_W-1:0] col;
        logic [OUT_COORD_W-1:0] row;
        logic                   done;
    } rgb_out_t;

    // directed pixels: color extremes, single channels and a frame restart mid-line
    localparam logic [PIXEL_W-1:0] CORNER_PIX [20] = '{
        16'hFFFF, 16'h0000, 16'hF800, 16'h07E0, 16'h001F, 16'h8410, 16'h7BEF, 16'h0001,
        16'h0800, 16'h0020, 16'h0000, 16'hF81F, 16'hFFE0, 16'h07FF, 16'hAAAA, 16'hFFFF,
        16'h5555, 16'h8000, 16'h0400, 16'h0010
    };

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [PIXEL_W-1:0]     pixel       = '0;
    logic                   frame_start = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic [OUT_COORD_W-1:0] out_col;
    logic [OUT_COORD_W-1:0] out_row;
    logic                   frame_done;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index   = CFG_CROP_X;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    // pixels waiting to be sent and output pixels still owed by the block
    cam_item_t camera_pixels [$];
    rgb_out_t  awaited_pixels [$];

    // shadow of the crop registers
    logic [XOFF_W-1:0] crop_x_reg = XOFF_W'(CROP_X_AT_RESET);
    logic [YOFF_W-1:0] crop_y_reg = YOFF_W'(CROP_Y_AT_RESET);

    // predicted scan position and next output grid position
    logic [8:0] src_col  = '0;
    logic [7:0] src_row  = '0;
    logic [6:0] next_col = '0;
    logic [6:0] next_row = '0;

    int send_gap     = 0;
    int stall_left   = 0;
    int calm_in      = 0;
    int calm_out     = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    crop_downscale_rgb565_unpack_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_col     (out_col),
        .out_row     (out_row),
        .frame_done  (frame_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    // crop position sampled by output index idx
    function automatic int crop_index(int idx);
        return idx * WINDOW / GRID;
    endfunction

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 3)
        begin
            calm = $urandom_range(100, 500);
            return 0;
        end
        if (r < 600)
            return 0;
        if (r < 930)
            return $urandom_range(1, 3);
        if (r < 990)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // advance the scan by one accepted pixel and queue the output pixel it yields, if any
    function automatic void pick_output_pixel(logic [PIXEL_W-1:0] pix, logic start);
        int       xoff;
        int       yoff;
        bit       row_hit;
        rgb_out_t px;
        // offsets clamp so the window stays inside the frame
        xoff = (int'(crop_x_reg) > WIN_X_MAX) ? WIN_X_MAX : int'(crop_x_reg);
        yoff = (int'(crop_y_reg) > WIN_Y_MAX) ? WIN_Y_MAX : int'(crop_y_reg);
        row_hit = 1'b0;
        // frame start clears everything before the pixel is used
        if (start)
        begin
            src_col  = '0;
            src_row  = '0;
            next_col = '0;
            next_row = '0;
        end
        if (src_row < FRAME_H && src_row >= yoff && next_row < GRID
            && crop_index(next_row) <= int'(src_row) - yoff)
        begin
            row_hit = 1'b1;
            if (src_col >= xoff && next_col < GRID
                && crop_index(next_col) <= int'(src_col) - xoff)
            begin
                // 5/6/5 widened by plain left shift
                px.red   = {pix[15:11], 3'b000};
                px.green = {pix[10:5], 2'b00};
                px.blue  = {pix[4:0], 3'b000};
                px.col   = next_col[OUT_COORD_W-1:0];
                px.row   = next_row[OUT_COORD_W-1:0];
                px.done  = (next_col == GRID - 1) && (next_row == GRID - 1);
                awaited_pixels = {awaited_pixels, px};
                next_col++;
            end
        end
        // end of line: next grid row only if this line was a sampled one
        if (int'(src_col) + 1 >= FRAME_W)
        begin
            src_col = '0;
            if (row_hit)
            begin
                next_row++;
                next_col = '0;
            end
            // row counter sticks past the last line until the next frame start
            if (src_row < FRAME_H)
                src_row++;
        end
        else
            src_col++;
    endfunction

    // pixel driver: one item per handshake, random gaps after each accepted item
    always @(posedge clk)
    begin : drive_pixels
        cam_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pick_output_pixel(pixel, frame_start);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (camera_pixels.size() > 0)
                begin
                    nxt = camera_pixels.pop_front();
                    pixel       <= nxt.pix;
                    frame_start <= nxt.start;
                    in_valid    <= 1'b1;
                    send_gap    = idle_length(calm_in);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor: random back-pressure, compare each item with the oldest prediction
    always @(posedge clk)
    begin : watch_pixels
        rgb_out_t want;
        rgb_out_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{red, green, blue, out_col, out_row, frame_done};
                if (awaited_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected output pixel: rgb %h %h %h at (%0d,%0d) done %b",
                                 $time, got.red, got.green, got.blue, got.col, got.row,
                                 got.done);
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t: expected rgb %h %h %h at (%0d,%0d) done %b,",
                                   $time, want.red, want.green, want.blue, want.col,
                                   want.row, want.done);
                            $display(" got rgb %h %h %h at (%0d,%0d) done %b",
                                     got.red, got.green, got.blue, got.col, got.row,
                                     got.done);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = idle_length(calm_out);
            end
        end
    end

    // hang detection: nothing moving on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no item moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one register write, taken once cfg_ready is seen
    task automatic write_crop_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_CROP_X)
            crop_x_reg = XOFF_W'(val);
        else if (idx == CFG_CROP_Y)
            crop_y_reg = YOFF_W'(val);
        cfg_valid <= 1'b0;
    endtask

    // wait until every pixel is sent and every output pixel seen, then let the pipe empty
    task automatic drain_stream();
        while (camera_pixels.size() != 0 || in_valid || awaited_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly frame tops a few lines deep, plus resumed streams and cut-off frames
    task automatic queue_random_frames(int budget);
        int        made;
        int        len;
        int        kind;
        cam_item_t it;
        made = 0;
        while (made < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
                len = $urandom_range(40, 1400);
            else if (kind < 92)
                len = $urandom_range(1, 400);
            else
                len = $urandom_range(1, 6);
            if (len > budget - made)
                len = budget - made;
            for (int k = 0; k < len; k++)
            begin
                it.pix = PIXEL_W'($urandom);
                // resumed streams carry no start; stray restarts now and then
                it.start = (k == 0 && (kind < 80 || kind >= 92))
                           || ($urandom_range(0, 499) == 0);
                camera_pixels = {camera_pixels, it};
            end
            made += len;
        end
    endtask

    initial
    begin
        cam_item_t it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // registers at their reset values
        queue_random_frames(300);
        drain_stream();

        // window at the left edge; row offset 1 clamps to 0
        write_crop_reg(CFG_CROP_X, CFG_DATA_W'(0));
        write_crop_reg(CFG_CROP_Y, CFG_DATA_W'(1));
        foreach (CORNER_PIX[k])
        begin
            it.pix   = CORNER_PIX[k];
            it.start = (k == 0 || k == 10 || k == 15);
            camera_pixels = {camera_pixels, it};
        end
        queue_random_frames(280);
        drain_stream();

        // window at the right edge
        write_crop_reg(CFG_CROP_X, CFG_DATA_W'(WIN_X_MAX));
        write_crop_reg(CFG_CROP_Y, CFG_DATA_W'(0));
        queue_random_frames(300);
        drain_stream();

        // both offsets past the limit
        write_crop_reg(CFG_CROP_X, '1);
        write_crop_reg(CFG_CROP_Y, '1);
        queue_random_frames(300);
        drain_stream();

        // some offset in between
        write_crop_reg(CFG_CROP_X, CFG_DATA_W'($urandom_range(1, WIN_X_MAX - 1)));
        write_crop_reg(CFG_CROP_Y, CFG_DATA_W'(0));
        queue_random_frames(300);
        drain_stream();

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (awaited_pixels.size() != 0)
        begin
            mismatches += awaited_pixels.size();
            $display("%0d predicted output pixels never came", awaited_pixels.size());
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
